>>> hw/rtl/bsim_pkg.sv
// Shared types and constants for the bank switch and IRQ mapper.
`timescale 1ns / 1ps

package bsim_pkg;

  localparam int TICKS_W = 10;            // three times an 8-bit cycle count
  localparam int ACC_W   = 11;            // prescaler plus one item's ticks
  localparam int PRESC_W = 9;
  localparam logic [ACC_W-1:0] TICKS_PER_LINE = 11'd341;
  localparam logic [15:0] ADDR_MASK_RESET = 16'hFFFF;
  localparam int QDEPTH = 2;              // power of two
  localparam int QAW    = $clog2(QDEPTH);
  localparam int NUM_CHR = 8;

  // Register addresses after masking
  localparam logic [15:0] ADDR_PRG_FIRST  = 16'h8000;
  localparam logic [15:0] ADDR_PRG_SECOND = 16'hA000;
  localparam logic [15:0] ADDR_MIRROR     = 16'h9000;
  localparam logic [15:0] ADDR_SWAP       = 16'h9008;
  localparam logic [15:0] ADDR_IRQ_LO     = 16'hF000;
  localparam logic [15:0] ADDR_IRQ_HI     = 16'hF004;
  localparam logic [15:0] ADDR_IRQ_CTRL   = 16'hF008;
  localparam logic [15:0] ADDR_IRQ_ACK    = 16'hF00C;
  localparam logic [15:0] PRG_DECODE      = 16'hFFF3;  // PRG selects ignore bits 3:2
  localparam logic [3:0]  CHR_PAGE_FIRST  = 4'hB;
  localparam logic [3:0]  CHR_PAGE_LAST   = 4'hE;
  localparam logic [7:0]  MIRROR_IGNORE   = 8'hFF;

  typedef struct packed {
    logic        opcode;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  cycles;
  } in_word_t;

  typedef struct packed {
    logic       prg_update;
    logic [2:0] prg_slot;
    logic [7:0] prg_bank;
    logic       chr_update;
    logic [2:0] chr_slot;
    logic [7:0] chr_bank;
    logic       mirror_update;
    logic [1:0] mirror_mode;
    logic       irq_line;
  } out_word_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PRG,
    OP_MIRROR,
    OP_SWAP,
    OP_CHR,
    OP_LATCH_LO,
    OP_LATCH_HI,
    OP_IRQ_CTRL,
    OP_IRQ_ACK,
    OP_CYCLES
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               prg_second;   // second PRG window (always slot 5)
    logic [2:0]         chr_idx;
    logic               chr_hi;       // high nibble of the CHR register
    logic [7:0]         data;
    logic [TICKS_W-1:0] ticks;
  } cmd_t;

  localparam logic [2:0] PRG_SLOT_FIRST   = 3'd4;
  localparam logic [2:0] PRG_SLOT_SECOND  = 3'd5;
  localparam logic [2:0] PRG_SLOT_SWAPPED = 3'd6;

endpackage

>>> hw/rtl/bsim_front.sv
// Front end: address mask register, input decode and cycle scaling.
`timescale 1ns / 1ps

module bsim_front #(
  parameter int MAX_CYCLES = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  bsim_pkg::in_word_t in_word,
  input  logic               q_full,
  output logic               q_push,
  output bsim_pkg::cmd_t     q_cmd
);

  logic [15:0] mask_r;
  logic [15:0] mask_nxt;
  logic [15:0] a;
  logic [3:0]  page;
  logic [3:0]  sub;
  logic [3:0]  page_off;
  logic [1:0]  v;
  logic [7:0]  c_sat;
  logic [9:0]  max_c;

  assign mask_nxt = cfg_valid ? cfg_data : mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= bsim_pkg::ADDR_MASK_RESET;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  assign q_push   = in_valid && !q_full;
  assign a        = in_word.address & mask_r;
  assign page     = a[15:12];
  assign sub      = a[3:0];
  assign page_off = page - bsim_pkg::CHR_PAGE_FIRST;
  assign v        = (sub < 4'd4) ? sub[1:0] : sub[3:2];
  assign max_c    = 10'(MAX_CYCLES);
  assign c_sat    = ({2'b00, in_word.cycles} > max_c) ? max_c[7:0] : in_word.cycles;

  always_comb begin
    q_cmd            = '0;
    q_cmd.op         = bsim_pkg::OP_NONE;
    q_cmd.data       = in_word.data;
    q_cmd.chr_idx    = {page_off[1:0], v[1]};
    q_cmd.chr_hi     = v[0];
    q_cmd.prg_second = a[13];
    q_cmd.ticks      = {1'b0, c_sat, 1'b0} + {2'b00, c_sat};
    if (in_word.opcode) begin
      q_cmd.op = bsim_pkg::OP_CYCLES;
    end else if ((a & bsim_pkg::PRG_DECODE) == bsim_pkg::ADDR_PRG_FIRST ||
                 (a & bsim_pkg::PRG_DECODE) == bsim_pkg::ADDR_PRG_SECOND) begin
      q_cmd.op = bsim_pkg::OP_PRG;
    end else if (a == bsim_pkg::ADDR_MIRROR) begin
      // 0xFF leaves mirroring alone
      q_cmd.op = (in_word.data != bsim_pkg::MIRROR_IGNORE) ? bsim_pkg::OP_MIRROR
                                                          : bsim_pkg::OP_NONE;
    end else if (a == bsim_pkg::ADDR_SWAP) begin
      q_cmd.op = bsim_pkg::OP_SWAP;
    end else if (page >= bsim_pkg::CHR_PAGE_FIRST && page <= bsim_pkg::CHR_PAGE_LAST &&
                 a[11:4] == 8'h00 &&
                 (sub <= 4'd4 || sub == 4'd8 || sub == 4'd12)) begin
      q_cmd.op = bsim_pkg::OP_CHR;
    end else if (a == bsim_pkg::ADDR_IRQ_LO) begin
      q_cmd.op = bsim_pkg::OP_LATCH_LO;
    end else if (a == bsim_pkg::ADDR_IRQ_HI) begin
      q_cmd.op = bsim_pkg::OP_LATCH_HI;
    end else if (a == bsim_pkg::ADDR_IRQ_CTRL) begin
      q_cmd.op = bsim_pkg::OP_IRQ_CTRL;
    end else if (a == bsim_pkg::ADDR_IRQ_ACK) begin
      q_cmd.op = bsim_pkg::OP_IRQ_ACK;
    end
  end

endmodule

>>> hw/rtl/bsim_queue.sv
// Short command queue between the decode front end and the execute back end.
`timescale 1ns / 1ps

module bsim_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bsim_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output bsim_pkg::cmd_t pop_cmd
);

  bsim_pkg::cmd_t            mem [bsim_pkg::QDEPTH];
  logic [bsim_pkg::QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [bsim_pkg::QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [bsim_pkg::QAW:0]    cnt_r, cnt_nxt;
  logic                      do_push, do_pop;

  assign full      = (cnt_r == (bsim_pkg::QAW + 1)'(bsim_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + {{bsim_pkg::QAW{1'b0}}, do_push} - {{bsim_pkg::QAW{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> hw/rtl/bsim_back.sv
// Back end: bank and IRQ state, line counter iteration and result register.
`timescale 1ns / 1ps

module bsim_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  bsim_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output bsim_pkg::out_word_t out_word
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_COUNT = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [7:0]                    chr_r   [bsim_pkg::NUM_CHR];
  logic [7:0]                    chr_nxt [bsim_pkg::NUM_CHR];
  logic                          swap_r, swap_nxt;
  logic [1:0]                    en_r, en_nxt;
  logic [7:0]                    count_r, count_nxt;
  logic [7:0]                    reload_r, reload_nxt;
  logic [bsim_pkg::PRESC_W-1:0]  presc_r, presc_nxt;
  logic                          level_r, level_nxt;
  logic [bsim_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  bsim_pkg::out_word_t           out_word_r, res;
  logic                          out_free, load_out;
  logic [7:0]                    chr_old, chr_new, count_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign chr_old   = chr_r[q_cmd.chr_idx];
  assign chr_new   = q_cmd.chr_hi ? {q_cmd.data[3:0], chr_old[3:0]}
                                  : {chr_old[7:4], q_cmd.data[3:0]};
  assign count_inc = count_r + 8'd1;

  always_comb begin
    state_nxt  = state_r;
    chr_nxt    = chr_r;
    swap_nxt   = swap_r;
    en_nxt     = en_r;
    count_nxt  = count_r;
    reload_nxt = reload_r;
    presc_nxt  = presc_r;
    level_nxt  = level_r;
    acc_nxt    = acc_r;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    res        = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          load_out = 1'b1;
          case (q_cmd.op)
            bsim_pkg::OP_PRG: begin
              res.prg_update = 1'b1;
              res.prg_bank   = q_cmd.data;
              if (q_cmd.prg_second) begin
                res.prg_slot = bsim_pkg::PRG_SLOT_SECOND;
              end else begin
                res.prg_slot = swap_r ? bsim_pkg::PRG_SLOT_SWAPPED
                                      : bsim_pkg::PRG_SLOT_FIRST;
              end
            end
            bsim_pkg::OP_MIRROR: begin
              res.mirror_update = 1'b1;
              res.mirror_mode   = q_cmd.data[1:0];
            end
            bsim_pkg::OP_SWAP: begin
              swap_nxt = q_cmd.data[1];
            end
            bsim_pkg::OP_CHR: begin
              chr_nxt[q_cmd.chr_idx] = chr_new;
              res.chr_update = 1'b1;
              res.chr_slot   = q_cmd.chr_idx;
              res.chr_bank   = chr_new;
            end
            bsim_pkg::OP_LATCH_LO: begin
              reload_nxt = {reload_r[7:4], q_cmd.data[3:0]};
              level_nxt  = 1'b0;
            end
            bsim_pkg::OP_LATCH_HI: begin
              reload_nxt = {q_cmd.data[3:0], reload_r[3:0]};
              level_nxt  = 1'b0;
            end
            bsim_pkg::OP_IRQ_CTRL: begin
              en_nxt    = q_cmd.data[1:0];
              count_nxt = reload_r;
              presc_nxt = '0;
              level_nxt = 1'b0;
            end
            bsim_pkg::OP_IRQ_ACK: begin
              en_nxt    = {en_r[0], en_r[0]};
              level_nxt = 1'b0;
            end
            bsim_pkg::OP_CYCLES: begin
              // counting disabled: nothing changes, report the line
              if (en_r[1]) begin
                acc_nxt   = {2'b00, presc_r} + {1'b0, q_cmd.ticks};
                load_out  = 1'b0;
                state_nxt = S_COUNT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_COUNT: begin
        if (acc_r >= bsim_pkg::TICKS_PER_LINE) begin
          acc_nxt = acc_r - bsim_pkg::TICKS_PER_LINE;
          if (count_inc == 8'd0) begin
            count_nxt = reload_r;
            level_nxt = 1'b1;
          end else begin
            count_nxt = count_inc;
          end
        end else if (out_free) begin
          presc_nxt = acc_r[bsim_pkg::PRESC_W-1:0];
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    res.irq_line = level_nxt;
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (load_out) begin
      out_word_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int i = 0; i < bsim_pkg::NUM_CHR; i++) begin
        chr_r[i] <= 8'(i);
      end
      swap_r      <= 1'b0;
      en_r        <= 2'b00;
      count_r     <= 8'd0;
      reload_r    <= 8'd0;
      presc_r     <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chr_r       <= chr_nxt;
      swap_r      <= swap_nxt;
      en_r        <= en_nxt;
      count_r     <= count_nxt;
      reload_r    <= reload_nxt;
      presc_r     <= presc_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/bank_switch_irq_mapper.sv
// Top level of the bank switch and IRQ mapper.
`timescale 1ns / 1ps

// Bank switching and scanline IRQ mapper. Each input word is a CPU register
// write (opcode 0) or an item of elapsed CPU time (opcode 1); each produces
// exactly one result word with the PRG, CHR and mirroring updates it caused
// and the IRQ line level afterwards. The front end masks the address with
// the cfg register (reset 0xFFFF), decodes it and scales the cycle count by
// three; a two-entry command queue separates it from the back end, which
// holds all bank and IRQ state. Writes stream at one per cycle while the
// output does not stall; each word is registered in the queue, then the
// back end registers its result and raises out_valid. A cycles item with
// counting enabled walks the line wraps it causes (0 to 3), the prescaler
// subtracting one line of 341 ticks per cycle; the back end pops no new
// command from the queue until that loop is done and its result is loaded.
// Write the cfg register only while the block is idle; cfg_ready is always 1.
module bank_switch_irq_mapper #(
  parameter int MAX_CYCLES = 255   // cycle counts above this are saturated
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  bsim_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output bsim_pkg::out_word_t out_word
);

  logic           q_push, q_full, q_pop, q_valid;
  bsim_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;
  // Hold input while the queue is full.
  assign in_stall  = q_full;

  bsim_front #(
    .MAX_CYCLES(MAX_CYCLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  bsim_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_cmd   (pop_cmd)
  );

  bsim_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

>>> sim/bank_switch_irq_mapper_tb.sv
// Testbench for the bank switch and IRQ mapper: directed table, then random words.
`timescale 1ns / 1ps

module bank_switch_irq_mapper_tb;

  // Block setup and run shape
  localparam int MAX_CYCLES   = 255;
  localparam int LINE_TICKS   = 341;   // prescaler ticks per scanline
  localparam int LONG_HOLD    = 200;   // receiver hold-off while the sender keeps pushing
  localparam int DRAIN_CYCLES = 20;    // tail after the last result, catches any extra word
  localparam int REPORT_MAX   = 10;

  // Opcodes of an input word
  localparam logic OPC_WRITE  = 1'b0;
  localparam logic OPC_CYCLES = 1'b1;

  // Register addresses after masking
  localparam logic [15:0] A_PRG_FIRST  = bsim_pkg::ADDR_PRG_FIRST;
  localparam logic [15:0] A_PRG_SECOND = bsim_pkg::ADDR_PRG_SECOND;
  localparam logic [15:0] A_MIRROR     = bsim_pkg::ADDR_MIRROR;
  localparam logic [15:0] A_SWAP       = bsim_pkg::ADDR_SWAP;
  localparam logic [15:0] A_IRQ_LO     = bsim_pkg::ADDR_IRQ_LO;
  localparam logic [15:0] A_IRQ_HI     = bsim_pkg::ADDR_IRQ_HI;
  localparam logic [15:0] A_IRQ_CTRL   = bsim_pkg::ADDR_IRQ_CTRL;
  localparam logic [15:0] A_IRQ_ACK    = bsim_pkg::ADDR_IRQ_ACK;
  localparam logic [15:0] PRG_DECODE   = bsim_pkg::PRG_DECODE;
  localparam logic [3:0]  CHR_PAGE_FIRST = bsim_pkg::CHR_PAGE_FIRST;
  localparam logic [3:0]  CHR_PAGE_LAST  = bsim_pkg::CHR_PAGE_LAST;
  localparam logic [3:0]  CHR_SUBS [7] = '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h8, 4'hC};
  localparam logic [7:0]  MIRROR_IGNORE = bsim_pkg::MIRROR_IGNORE;

  // Address mask settings
  localparam logic [15:0] MASK_ALL  = 16'hFFFF;
  localparam logic [15:0] MASK_ALT  = 16'hF00C;
  localparam logic [15:0] MASK_NONE = 16'h0000;

  localparam bsim_pkg::out_word_t QUIET = '0;

  typedef struct packed {
    bsim_pkg::in_word_t  stim;
    logic                typed;   // expd holds a hand-written result
    bsim_pkg::out_word_t expd;
  } dir_row_t;

  // Directed words, mask at reset value and all state fresh from reset. Results
  // are typed in where obvious; the rest fall back to the predictor.
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{OPC_WRITE,  16'h0000, 8'h00, 8'h00}, 1'b1, QUIET},          // unmatched address
    '{'{OPC_CYCLES, 16'hFFFF, 8'hFF, 8'hFF}, 1'b1, QUIET},          // counting disabled
    '{'{OPC_WRITE,  16'h8000, 8'hFF, 8'h00}, 1'b1,
      '{1'b1, bsim_pkg::PRG_SLOT_FIRST, 8'hFF, 1'b0, 3'd0, 8'h00, 1'b0, 2'd0, 1'b0}},
    '{'{OPC_WRITE,  16'hA00C, 8'h00, 8'hFF}, 1'b1,
      '{1'b1, bsim_pkg::PRG_SLOT_SECOND, 8'h00, 1'b0, 3'd0, 8'h00, 1'b0, 2'd0, 1'b0}},
    '{'{OPC_WRITE,  16'h9000, 8'hFF, 8'h00}, 1'b1, QUIET},          // mirroring 0xFF dropped
    '{'{OPC_WRITE,  16'h9000, 8'h03, 8'h00}, 1'b1,
      '{1'b0, 3'd0, 8'h00, 1'b0, 3'd0, 8'h00, 1'b1, 2'd3, 1'b0}},
    '{'{OPC_WRITE,  16'h9008, 8'h02, 8'h00}, 1'b1, QUIET},          // set PRG swap
    '{'{OPC_WRITE,  16'h8004, 8'h5A, 8'h00}, 1'b1,
      '{1'b1, bsim_pkg::PRG_SLOT_SWAPPED, 8'h5A, 1'b0, 3'd0, 8'h00, 1'b0, 2'd0, 1'b0}},
    '{'{OPC_WRITE,  16'hB000, 8'h0F, 8'h00}, 1'b1,
      '{1'b0, 3'd0, 8'h00, 1'b1, 3'd0, 8'h0F, 1'b0, 2'd0, 1'b0}},
    '{'{OPC_WRITE,  16'hB001, 8'hFF, 8'h00}, 1'b1,
      '{1'b0, 3'd0, 8'h00, 1'b1, 3'd0, 8'hFF, 1'b0, 2'd0, 1'b0}},
    '{'{OPC_WRITE,  16'hE00C, 8'hF0, 8'h00}, 1'b1,
      '{1'b0, 3'd0, 8'h00, 1'b1, 3'd7, 8'h07, 1'b0, 2'd0, 1'b0}},
    '{'{OPC_WRITE,  16'hE008, 8'h0A, 8'h00}, 1'b0, QUIET},
    '{'{OPC_WRITE,  16'hC004, 8'hA3, 8'h00}, 1'b0, QUIET},
    '{'{OPC_WRITE,  16'hD002, 8'hC5, 8'h00}, 1'b0, QUIET},
    '{'{OPC_WRITE,  16'h9008, 8'h00, 8'h00}, 1'b0, QUIET},
    '{'{OPC_WRITE,  16'h8008, 8'h11, 8'h00}, 1'b0, QUIET},
    '{'{OPC_WRITE,  16'hF000, 8'h0F, 8'h00}, 1'b0, QUIET},
    '{'{OPC_WRITE,  16'hF004, 8'h0F, 8'h00}, 1'b0, QUIET},
    '{'{OPC_WRITE,  16'hF008, 8'h03, 8'h00}, 1'b0, QUIET},         // enable, count from 0xFF
    '{'{OPC_CYCLES, 16'h0000, 8'h00, 8'hFF}, 1'b0, QUIET},         // two full lines, IRQ rises
    '{'{OPC_CYCLES, 16'h0000, 8'h00, 8'h00}, 1'b0, QUIET},
    '{'{OPC_WRITE,  16'hB003, 8'hFF, 8'h00}, 1'b0, QUIET},         // line stays high
    '{'{OPC_WRITE,  16'hF00C, 8'h00, 8'h00}, 1'b0, QUIET},         // acknowledge
    '{'{OPC_WRITE,  16'hF008, 8'h00, 8'h00}, 1'b0, QUIET},         // disable
    '{'{OPC_WRITE,  16'hFFFF, 8'h00, 8'h00}, 1'b0, QUIET}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [15:0]         cfg_data;
  logic                in_valid;
  logic                in_stall;
  bsim_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  bsim_pkg::out_word_t out_word;

  // Predictor state: mapper registers as the block should hold them
  logic [15:0] addr_mask = MASK_ALL;
  logic [7:0]  chr_regs [8];
  logic        prg_swap   = 1'b0;
  logic [1:0]  irq_en     = 2'b00;
  logic [7:0]  irq_count  = 8'h00;
  logic [7:0]  irq_reload = 8'h00;
  int          presc_ticks = 0;
  logic        irq_lvl    = 1'b0;

  bsim_pkg::out_word_t bank_updates_q [$];   // results still owed by the block
  bsim_pkg::out_word_t want;
  int        words_sent = 0;
  int        words_seen = 0;
  int        mismatches = 0;
  bit        gaps_on    = 1'b1;    // random idling on both sides
  bit        hold_req   = 1'b0;    // ask the receiver for one long hold-off

  bank_switch_irq_mapper #(
    .MAX_CYCLES(MAX_CYCLES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the predictor by one accepted word and return the result it owes.
  function automatic bsim_pkg::out_word_t apply_cpu_word(bsim_pkg::in_word_t w);
    bsim_pkg::out_word_t r;
    logic [15:0] a;
    logic [3:0]  page;
    logic [3:0]  sub;
    logic [1:0]  nib_sel;
    logic [2:0]  chr_sel;
    int          c;
    int          acc;
    r = '0;
    if (w.opcode == OPC_WRITE) begin
      a    = w.address & addr_mask;
      page = a[15:12];
      sub  = a[3:0];
      if ((a & PRG_DECODE) == A_PRG_FIRST) begin
        r.prg_update = 1'b1;
        r.prg_slot   = prg_swap ? bsim_pkg::PRG_SLOT_SWAPPED : bsim_pkg::PRG_SLOT_FIRST;
        r.prg_bank   = w.data;
      end else if ((a & PRG_DECODE) == A_PRG_SECOND) begin
        r.prg_update = 1'b1;
        r.prg_slot   = bsim_pkg::PRG_SLOT_SECOND;
        r.prg_bank   = w.data;
      end else if (a == A_MIRROR) begin
        if (w.data != MIRROR_IGNORE) begin
          r.mirror_update = 1'b1;
          r.mirror_mode   = w.data[1:0];
        end
      end else if (a == A_SWAP) begin
        prg_swap = w.data[1];
      end else if (page >= CHR_PAGE_FIRST && page <= CHR_PAGE_LAST && a[11:4] == 8'h00 &&
                   (sub <= 4'h4 || sub == 4'h8 || sub == 4'hC)) begin
        // Low sub-addresses count 0..3; 4, 8 and C are the same selects on bits 3:2.
        // Bit 1 of the select picks the odd register, bit 0 the high nibble.
        nib_sel = (sub < 4'h4) ? sub[1:0] : sub[3:2];
        chr_sel = 3'((int'(page) - int'(CHR_PAGE_FIRST)) * 2 + int'(nib_sel[1]));
        if (nib_sel[0])
          chr_regs[chr_sel][7:4] = w.data[3:0];
        else
          chr_regs[chr_sel][3:0] = w.data[3:0];
        r.chr_update = 1'b1;
        r.chr_slot   = chr_sel;
        r.chr_bank   = chr_regs[chr_sel];
      end else if (a == A_IRQ_LO) begin
        irq_reload[3:0] = w.data[3:0];
        irq_lvl = 1'b0;
      end else if (a == A_IRQ_HI) begin
        irq_reload[7:4] = w.data[3:0];
        irq_lvl = 1'b0;
      end else if (a == A_IRQ_CTRL) begin
        irq_en      = w.data[1:0];
        irq_count   = irq_reload;
        presc_ticks = 0;
        irq_lvl     = 1'b0;
      end else if (a == A_IRQ_ACK) begin
        irq_en  = {2{irq_en[0]}};
        irq_lvl = 1'b0;
      end
    end else begin
      c = int'(w.cycles);
      if (c > MAX_CYCLES)
        c = MAX_CYCLES;
      if (irq_en[1]) begin
        // Three ticks per CPU cycle; every full line bumps the counter, a wrap reloads it.
        acc = presc_ticks + 3 * c;
        while (acc >= LINE_TICKS) begin
          acc -= LINE_TICKS;
          irq_count = irq_count + 8'd1;
          if (irq_count == 8'h00) begin
            irq_count = irq_reload;
            irq_lvl   = 1'b1;
          end
        end
        presc_ticks = acc;
      end
    end
    r.irq_line = irq_lvl;
    return r;
  endfunction

  // Mostly well-formed register writes and cycle counts, with some noise.
  // Bits the mask drops are filled with random junk.
  function automatic bsim_pkg::in_word_t random_word();
    bsim_pkg::in_word_t w;
    logic [15:0] junk;
    int          pick;
    w.opcode  = OPC_WRITE;
    w.address = 16'($urandom);
    w.data    = 8'($urandom);
    w.cycles  = 8'($urandom);
    junk      = 16'($urandom) & ~addr_mask;
    pick      = $urandom_range(0, 19);
    case (pick)
      0, 1, 2, 3, 4, 5: begin
        w.opcode = OPC_CYCLES;
        if ($urandom_range(0, 1) == 1)
          w.cycles = 8'($urandom_range(200, 255));
      end
      6, 7: w.address = A_PRG_FIRST | (16'($urandom) & 16'h000C) | junk;
      8:    w.address = A_PRG_SECOND | (16'($urandom) & 16'h000C) | junk;
      9: begin
        w.address = A_MIRROR | junk;
        if ($urandom_range(0, 7) == 0)
          w.data = MIRROR_IGNORE;
      end
      10:   w.address = A_SWAP | junk;
      11, 12, 13: begin
        w.address = {4'($urandom_range(CHR_PAGE_FIRST, CHR_PAGE_LAST)), 8'h00,
                     CHR_SUBS[$urandom_range(0, 6)]} | junk;
        // drop in a bad sub-address now and then
        if ($urandom_range(0, 3) == 0)
          w.address[3:0] = 4'($urandom);
      end
      14:   w.address = A_IRQ_LO | junk;
      15: begin
        w.address = A_IRQ_HI | junk;
        if ($urandom_range(0, 1) == 1)
          w.data[3:0] = 4'hF;   // high reload, so wraps come soon
      end
      16: begin
        w.address = A_IRQ_CTRL | junk;
        if ($urandom_range(0, 1) == 1)
          w.data[1] = 1'b1;
      end
      17:   w.address = A_IRQ_ACK | junk;
      default: ;
    endcase
    return w;
  endfunction

  function automatic string fmt_word(bsim_pkg::out_word_t x);
    return $sformatf("prg %b/%0d/%h chr %b/%0d/%h mirror %b/%0d irq %b",
                     x.prg_update, x.prg_slot, x.prg_bank, x.chr_update, x.chr_slot,
                     x.chr_bank, x.mirror_update, x.mirror_mode, x.irq_line);
  endfunction

  // Offer one word, hold it until taken, then log what the block owes for it.
  task automatic offer_word(bsim_pkg::in_word_t w, logic typed,
                            bsim_pkg::out_word_t typed_res);
    bsim_pkg::out_word_t pred;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    pred = apply_cpu_word(w);
    bank_updates_q.push_back(typed ? typed_res : pred);
    words_sent++;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++)
      offer_word(random_word(), 1'b0, QUIET);
  endtask

  // Write the mask once the block has drained; every word yields a result,
  // so an empty backlog means the block is idle.
  task automatic set_addr_mask(logic [15:0] m);
    in_valid <= 1'b0;
    while (words_seen < words_sent) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    addr_mask = m;
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    for (int k = 0; k < 8; k++)
      chr_regs[k] = 8'(k);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_addr_mask(MASK_ALL);
    for (int i = 0; i < DIR_ROWS; i++)
      offer_word(DIR_TAB[i].stim, DIR_TAB[i].typed, DIR_TAB[i].expd);
    run_random(120);

    // Hold the receiver off while the sender streams, so the block backs up.
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    run_random(30);
    gaps_on  = 1'b1;

    set_addr_mask(MASK_ALT);
    run_random(120);
    set_addr_mask(MASK_NONE);
    run_random(30);
    set_addr_mask(16'($urandom) | MASK_ALT);
    run_random(100);

    // Back-to-back tail with no idling.
    set_addr_mask(MASK_ALL);
    gaps_on = 1'b0;
    run_random(80);
    in_valid <= 1'b0;

    while (words_seen < words_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && bank_updates_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Receiver: random stall bursts, plus the one long hold-off on request.
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each taken result with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (bank_updates_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("mismatch: unexpected word %s", fmt_word(out_word));
      end else begin
        want = bank_updates_q.pop_front();
        if (out_word.prg_update !== want.prg_update || out_word.prg_slot !== want.prg_slot ||
            out_word.prg_bank !== want.prg_bank || out_word.chr_update !== want.chr_update ||
            out_word.chr_slot !== want.chr_slot || out_word.chr_bank !== want.chr_bank ||
            out_word.mirror_update !== want.mirror_update ||
            out_word.mirror_mode !== want.mirror_mode || out_word.irq_line !== want.irq_line) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch on word %0d: expected %s, got %s", words_seen,
                     fmt_word(want), fmt_word(out_word));
        end
      end
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
